>>> rtl/bms_ready_wait_supervisor_assert.svh
// Assertion macros shared by the supervisor RTL.
`ifndef BMS_READY_WAIT_SUPERVISOR_ASSERT_SVH
`define BMS_READY_WAIT_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/brws_pkg.sv
package brws_pkg;

	localparam logic [7:0] READY_CODE = 8'hAA;

	localparam logic [15:0] LIMIT_PERIOD_RST  = 16'd250;
	localparam logic [15:0] STATUS_PERIOD_RST = 16'd500;
	localparam logic [19:0] FRAME_TIMEOUT_RST = 20'd5000;
	localparam logic [19:0] DEADLINE_RST      = 20'd59700;
	localparam logic [15:0] OPEN_LIMIT_RST    = 16'd1000;

	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIMIT_PERIOD  = 3'd0,
		CFG_STATUS_PERIOD = 3'd1,
		CFG_FRAME_TIMEOUT = 3'd2,
		CFG_DEADLINE      = 3'd3,
		CFG_OPEN_LIMIT    = 3'd4,
		CFG_PROTOCOL_2011 = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_STAY       = 3'd0,
		PH_PILLAR     = 3'd1,
		PH_COMM_BREAK = 3'd2,
		PH_STOP       = 3'd3,
		PH_CHG_BREAK  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		REASON_NONE      = 2'd0,
		REASON_USER      = 2'd1,
		REASON_CONN_OPEN = 2'd2
	} reason_t;

	typedef enum logic {
		KIND_ENTER = 1'b0,
		KIND_POLL  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] now_ticks;
		logic        ready_frame_seen;
		logic [7:0]  ready_frame_status;
		logic        error_frame_seen;
		logic        discharge_enable;
		logic        stop_by_key_pending;
		logic        connector_closed;
	} cmd_t;

	typedef struct packed {
		logic    send_limit_frame;
		logic    send_status_frame;
		logic    send_warning_frame;
		logic    ready_timeout_flag;
		phase_t  next_phase;
		reason_t stop_reason;
	} rsp_t;

endpackage

>>> rtl/bms_ready_wait_supervisor.sv
// Wait-for-battery-ready supervisor.
// Command channel (cmd_valid / cmd_stall / cmd): each transfer either enters
// the phase or is one polling pass with the current tick count and the flags
// gathered since the previous pass.
// Result channel (rsp_valid / rsp_stall / rsp): exactly one result per command,
// in command order: frame resend requests, the timeout flag, the next phase
// and the stop reason.
// The command lands in an input register; the decision is made from it and
// written to the result register together with the supervisor state.
// Throughput is one command per cycle while the result is not stalled; the
// only loop is the state update made with each decision.
// A stalled result holds in the result register; the input register still
// takes a command while the result register is empty or being drained, so
// cmd_stall rises only when both registers are full.
// Reset (arst_n low) empties both registers, loads the default periods and
// clears all timers and flags; the phase is inactive until an enter command.
// Configuration writes through cfg_we / cfg_index / cfg_data take effect at
// the next edge and are expected only while the block is idle.
module bms_ready_wait_supervisor
	import brws_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_t                  cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "bms_ready_wait_supervisor_assert.svh"

	// configuration
	logic [15:0] limit_period_q;
	logic [15:0] status_period_q;
	logic [19:0] frame_timeout_q;
	logic [19:0] deadline_q;
	logic [15:0] open_limit_q;
	logic        protocol_2011_q;

	// supervisor state
	logic [31:0] limit_sent_at_q;
	logic [31:0] status_sent_at_q;
	logic [31:0] ready_seen_at_q;
	logic [31:0] phase_entered_at_q;
	logic [31:0] open_since_q;
	logic        deadline_armed_q;
	logic        ready_valid_q;
	logic [7:0]  ready_status_q;
	logic        error_valid_q;
	logic        open_timing_q;
	logic        timeout_bit_q;
	logic        phase_active_q;

	// pipeline
	logic valid_s1;
	cmd_t cmd_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic out_free;
	logic advance;

	// next-state values
	logic [31:0] limit_sent_at_d;
	logic [31:0] status_sent_at_d;
	logic [31:0] ready_seen_at_d;
	logic [31:0] phase_entered_at_d;
	logic [31:0] open_since_d;
	logic        deadline_armed_d;
	logic        ready_valid_d;
	logic [7:0]  ready_status_d;
	logic        error_valid_d;
	logic        open_timing_d;
	logic        timeout_bit_d;
	logic        phase_active_d;
	rsp_t        rsp_d;

	logic [31:0] now;
	logic [31:0] since_limit;
	logic [31:0] since_status;
	logic [31:0] since_ready;
	logic [31:0] since_entry;
	logic [31:0] since_open;
	logic        frame_late;
	logic        frame_half_late;
	logic        deadline_hit;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign advance   = valid_s1 && out_free;
	assign cmd_stall = valid_s1 && !out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign now = cmd_s1.now_ticks;

	always_comb begin
		limit_sent_at_d    = limit_sent_at_q;
		status_sent_at_d   = status_sent_at_q;
		ready_seen_at_d    = ready_seen_at_q;
		phase_entered_at_d = phase_entered_at_q;
		open_since_d       = open_since_q;
		deadline_armed_d   = deadline_armed_q;
		ready_valid_d      = ready_valid_q;
		ready_status_d     = ready_status_q;
		error_valid_d      = error_valid_q;
		open_timing_d      = open_timing_q;
		timeout_bit_d      = timeout_bit_q;
		phase_active_d     = phase_active_q;

		rsp_d                    = '0;
		rsp_d.next_phase         = PH_STAY;
		rsp_d.stop_reason        = REASON_NONE;

		since_limit     = now - limit_sent_at_q;
		since_status    = now - status_sent_at_q;
		since_entry     = now - phase_entered_at_q;
		// a ready frame on this pass restarts the timeout window at zero
		since_ready     = cmd_s1.ready_frame_seen ? 32'd0 : (now - ready_seen_at_q);
		frame_late      = since_ready > {12'd0, frame_timeout_q};
		frame_half_late = since_ready > {13'd0, frame_timeout_q[19:1]};
		deadline_hit    = deadline_armed_q && (since_entry > {12'd0, deadline_q});
		// a line that opens on this pass starts timing at zero
		since_open      = (!cmd_s1.connector_closed && !open_timing_q) ? 32'd0
			: (now - open_since_q);

		if (cmd_s1.kind == KIND_ENTER) begin
			ready_valid_d      = 1'b0;
			error_valid_d      = 1'b0;
			open_timing_d      = 1'b0;
			limit_sent_at_d    = now;
			status_sent_at_d   = now;
			ready_seen_at_d    = now;
			phase_entered_at_d = now;
			deadline_armed_d   = 1'b1;
			phase_active_d     = 1'b1;
			rsp_d.send_limit_frame  = 1'b1;
			rsp_d.send_status_frame = 1'b1;
		end else if (phase_active_q) begin
			// resend decisions use the state from before this pass's frames
			if (since_limit > {16'd0, limit_period_q} && !ready_valid_q
				&& ready_status_q != READY_CODE) begin
				rsp_d.send_limit_frame = 1'b1;
				limit_sent_at_d        = now;
			end
			if (since_status > {16'd0, status_period_q}) begin
				rsp_d.send_status_frame = 1'b1;
				status_sent_at_d        = now;
			end

			if (cmd_s1.ready_frame_seen) begin
				ready_valid_d   = 1'b1;
				ready_status_d  = cmd_s1.ready_frame_status;
				ready_seen_at_d = now;
			end
			if (cmd_s1.error_frame_seen)
				error_valid_d = 1'b1;

			// later checks override earlier ones
			if (frame_late) begin
				timeout_bit_d    = 1'b1;
				rsp_d.next_phase = PH_COMM_BREAK;
			end else if (frame_half_late && protocol_2011_q) begin
				rsp_d.send_warning_frame = 1'b1;
			end else begin
				timeout_bit_d = 1'b0;
			end

			if (deadline_hit) begin
				timeout_bit_d    = 1'b1;
				rsp_d.next_phase = PH_COMM_BREAK;
			end

			if (ready_valid_d && ready_status_d == READY_CODE) begin
				deadline_armed_d = 1'b0;
				rsp_d.next_phase = PH_PILLAR;
			end

			if (error_valid_d)
				rsp_d.next_phase = PH_COMM_BREAK;

			if (!cmd_s1.discharge_enable) begin
				rsp_d.stop_reason = cmd_s1.stop_by_key_pending ? REASON_NONE : REASON_USER;
				rsp_d.next_phase  = PH_STOP;
			end

			// connector debounce
			if (!cmd_s1.connector_closed) begin
				open_timing_d = 1'b1;
				if (!open_timing_q)
					open_since_d = now;
			end else begin
				open_timing_d = 1'b0;
			end
			if (open_timing_d && since_open > {16'd0, open_limit_q}) begin
				open_timing_d     = 1'b0;
				rsp_d.stop_reason = REASON_CONN_OPEN;
				rsp_d.next_phase  = PH_CHG_BREAK;
			end

			if (rsp_d.next_phase != PH_STAY)
				phase_active_d = 1'b0;
		end

		rsp_d.ready_timeout_flag = timeout_bit_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_period_q  <= LIMIT_PERIOD_RST;
			status_period_q <= STATUS_PERIOD_RST;
			frame_timeout_q <= FRAME_TIMEOUT_RST;
			deadline_q      <= DEADLINE_RST;
			open_limit_q    <= OPEN_LIMIT_RST;
			protocol_2011_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LIMIT_PERIOD:  limit_period_q  <= cfg_data[15:0];
				CFG_STATUS_PERIOD: status_period_q <= cfg_data[15:0];
				CFG_FRAME_TIMEOUT: frame_timeout_q <= cfg_data;
				CFG_DEADLINE:      deadline_q      <= cfg_data;
				CFG_OPEN_LIMIT:    open_limit_q    <= cfg_data[15:0];
				CFG_PROTOCOL_2011: protocol_2011_q <= cfg_data[0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	// supervisor state, advanced once per decided command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_sent_at_q    <= '0;
			status_sent_at_q   <= '0;
			ready_seen_at_q    <= '0;
			phase_entered_at_q <= '0;
			open_since_q       <= '0;
			deadline_armed_q   <= 1'b0;
			ready_valid_q      <= 1'b0;
			ready_status_q     <= '0;
			error_valid_q      <= 1'b0;
			open_timing_q      <= 1'b0;
			timeout_bit_q      <= 1'b0;
			phase_active_q     <= 1'b0;
		end else if (advance) begin
			limit_sent_at_q    <= limit_sent_at_d;
			status_sent_at_q   <= status_sent_at_d;
			ready_seen_at_q    <= ready_seen_at_d;
			phase_entered_at_q <= phase_entered_at_d;
			open_since_q       <= open_since_d;
			deadline_armed_q   <= deadline_armed_d;
			ready_valid_q      <= ready_valid_d;
			ready_status_q     <= ready_status_d;
			error_valid_q      <= error_valid_d;
			open_timing_q      <= open_timing_d;
			timeout_bit_q      <= timeout_bit_d;
			phase_active_q     <= phase_active_d;
		end
	end

	// input register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!cmd_stall)
				valid_s1 <= cmd_valid;
			if (out_free)
				rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall)
			cmd_s1 <= cmd;
		if (advance)
			rsp_q <= rsp_d;
	end

	`BRWS_ASSERT_NEXT(a_advance_loads_rsp, clk, arst_n, advance, rsp_valid_q,
		"decided command did not reach the result register")
	`BRWS_ASSERT_NEXT(a_leave_clears_active, clk, arst_n,
		advance && rsp_d.next_phase != PH_STAY, !phase_active_q,
		"phase still active after a phase change")
	`BRWS_ASSERT_NOW(a_conn_break_reason, clk, arst_n,
		rsp_valid_q && rsp_q.next_phase == PH_CHG_BREAK,
		rsp_q.stop_reason == REASON_CONN_OPEN,
		"charge break without connector-open reason")
	`BRWS_ASSERT_NOW(a_reason_needs_stop, clk, arst_n,
		rsp_valid_q && rsp_q.stop_reason != REASON_NONE,
		rsp_q.next_phase == PH_STOP || rsp_q.next_phase == PH_CHG_BREAK,
		"stop reason given without a stopping phase")

endmodule
